// ===== design/wegs_pkg.sv =====
// ----------------------------------------------------------------------------
// wegs_pkg: shared types and constants of the wave grid step block
// Grid geometry, fixed-point widths, controller states and the command
// bundle that runs from the controller to the datapath.
// ----------------------------------------------------------------------------
package wegs_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int CELLS     = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int VAL_W     = 32;
    localparam int FRAC_W    = 24;
    localparam int COEF_W    = 24;
    localparam int DIM_W     = 7;
    localparam int STEPS_W   = 16;
    localparam int IDX_W     = 3;
    localparam int CFG_W     = 24;
    localparam int IN_DATA_W = 48;
    localparam int OUT_DATA_W = 48;

    // sweep: issue reads for CELLS + one row of lookahead, then drain the pipe
    localparam int ISSUE_N   = CELLS + MAX_COLS;
    localparam int PIPE_N    = 5;
    localparam int TOTAL     = ISSUE_N + PIPE_N;
    localparam int CNT_W     = $clog2(TOTAL);

    localparam int DIFF_W    = 35;
    localparam int MAG_W     = 34;
    localparam int PROD_W    = MAG_W + COEF_W;
    localparam int SUM_W     = 36;

    localparam logic signed [VAL_W-1:0] LIMIT = VAL_W'(10 <<< FRAC_W);

    localparam logic [IDX_W-1:0] REG_ROWS   = 3'd0;
    localparam logic [IDX_W-1:0] REG_COLS   = 3'd1;
    localparam logic [IDX_W-1:0] REG_COEF_H = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEF_V = 3'd3;
    localparam logic [IDX_W-1:0] REG_SRC_R  = 3'd4;
    localparam logic [IDX_W-1:0] REG_SRC_C  = 3'd5;

    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP,
        ST_READ,
        ST_RWAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic             clr;
        logic             issue;
        logic             kvalid;
        logic [CNT_W-1:0] cnt;
        logic             load;
        logic             step_start;
        logic             step_done;
        logic             rd_sel;
        logic             rd_cap;
    } t_cmd;

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'({1'b0, {(VAL_W-1){1'b1}}});
        lo = -hi - SUM_W'(1);
        if (v > hi) begin
            sat_val = hi[VAL_W-1:0];
        end else if (v < lo) begin
            sat_val = lo[VAL_W-1:0];
        end else begin
            sat_val = v[VAL_W-1:0];
        end
    endfunction

endpackage

// ===== design/wegs_ram.sv =====
// ----------------------------------------------------------------------------
// wegs_ram: simple dual-port RAM
// One write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module wegs_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/wegs_ctrl.sv =====
// ----------------------------------------------------------------------------
// wegs_ctrl: sequencer of the wave grid step block
// Runs the clearing pass, the step sweep and the cell read, and owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
module wegs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_s_tuser,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output wegs_pkg::t_cmd o_cmd
);
    import wegs_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_accept;

    assign w_accept = i_s_tvalid && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_CLEAR: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                    n_cnt   = '0;
                end
            end
            ST_IDLE: begin
                n_cnt = '0;
                if (w_accept) begin
                    n_state = (i_s_tuser == CMD_READ) ? ST_READ : ST_STEP;
                end
            end
            ST_STEP: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(TOTAL - 1)) begin
                    n_state = ST_OUT;
                    n_cnt   = '0;
                end
            end
            ST_READ:  n_state = ST_RWAIT;
            ST_RWAIT: n_state = ST_OUT;
            ST_OUT: begin
                if (i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.cnt        = r_cnt;
        o_cmd.clr        = (r_state == ST_CLEAR);
        o_cmd.issue      = (r_state == ST_STEP) && (r_cnt < CNT_W'(ISSUE_N));
        o_cmd.kvalid     = o_cmd.issue && (r_cnt >= CNT_W'(MAX_COLS));
        o_cmd.load       = w_accept;
        o_cmd.step_start = w_accept && (i_s_tuser == CMD_STEP);
        o_cmd.step_done  = (r_state == ST_STEP) && (r_cnt == CNT_W'(TOTAL - 1));
        o_cmd.rd_sel     = (r_state == ST_READ);
        o_cmd.rd_cap     = (r_state == ST_RWAIT);
        o_s_tready       = (r_state == ST_IDLE);
        o_m_tvalid       = (r_state == ST_OUT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_kvalid_in_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.kvalid |-> o_cmd.issue)
        else $error("prev read outside issue window");

    a_done_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.step_done |=> o_m_tvalid)
        else $error("step end did not present a result");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !o_m_tvalid && !o_cmd.clr)
        else $error("input taken while busy");

endmodule

// ===== design/wegs_dp.sv =====
// ----------------------------------------------------------------------------
// wegs_dp: datapath of the wave grid step block
// Two grid banks, a two-row shift line for the stencil window, a four-stage
// update pipe, configuration registers and the result register.
// ----------------------------------------------------------------------------
module wegs_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wegs_pkg::t_cmd                      i_cmd,
    input  logic [wegs_pkg::IN_DATA_W-1:0]      i_s_tdata,
    input  logic                                i_cfg_valid,
    input  logic [wegs_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [wegs_pkg::CFG_W-1:0]          i_cfg_data,
    output logic [wegs_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    output logic                                o_m_tuser
);
    import wegs_pkg::*;

    // configuration
    logic [DIM_W-1:0]  r_rows, r_cols;
    logic [COEF_W-1:0] r_coef_h, r_coef_v;
    logic [ROW_W-1:0]  r_src_r;
    logic [COL_W-1:0]  r_src_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows   <= DIM_W'(64);
            r_cols   <= DIM_W'(64);
            r_coef_h <= '0;
            r_coef_v <= '0;
            r_src_r  <= ROW_W'(32);
            r_src_c  <= COL_W'(32);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ROWS:   r_rows   <= i_cfg_data[DIM_W-1:0];
                REG_COLS:   r_cols   <= i_cfg_data[DIM_W-1:0];
                REG_COEF_H: r_coef_h <= i_cfg_data[COEF_W-1:0];
                REG_COEF_V: r_coef_v <= i_cfg_data[COEF_W-1:0];
                REG_SRC_R:  r_src_r  <= i_cfg_data[ROW_W-1:0];
                REG_SRC_C:  r_src_c  <= i_cfg_data[COL_W-1:0];
                default: ;
            endcase
        end
    end

    logic [DIM_W-1:0] w_nr, w_nc;
    always_comb begin
        w_nr = r_rows;
        if (r_rows < DIM_W'(3)) w_nr = DIM_W'(3);
        else if (r_rows > DIM_W'(MAX_ROWS)) w_nr = DIM_W'(MAX_ROWS);
        w_nc = r_cols;
        if (r_cols < DIM_W'(3)) w_nc = DIM_W'(3);
        else if (r_cols > DIM_W'(MAX_COLS)) w_nc = DIM_W'(MAX_COLS);
    end

    function automatic logic interior(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                                      input logic [DIM_W-1:0] nr, input logic [DIM_W-1:0] nc);
        interior = (r != '0) && (c != '0) &&
                   (DIM_W'(r) + DIM_W'(1) < nr) && (DIM_W'(c) + DIM_W'(1) < nc);
    endfunction

    // latched command fields
    logic signed [VAL_W-1:0] r_amp;
    logic [ROW_W-1:0]        r_rr;
    logic [COL_W-1:0]        r_rc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_amp <= i_s_tdata[VAL_W-1:0];
            r_rr  <= i_s_tdata[VAL_W +: ROW_W];
            r_rc  <= i_s_tdata[VAL_W+ROW_W +: COL_W];
        end
    end

    // grid banks; r_bank names the bank that holds the current grid
    logic              r_bank;
    logic [ADDR_W-1:0] w_cur_addr, w_prv_addr, w_waddr;
    logic [VAL_W-1:0]  w_q0, w_q1, w_wdata;
    logic              w_we0, w_we1, w_wr;
    logic signed [VAL_W-1:0] w_cur_q, w_prv_q;

    assign w_cur_addr = i_cmd.rd_sel ? {r_rr, r_rc} : i_cmd.cnt[ADDR_W-1:0];
    assign w_prv_addr = 12'(i_cmd.cnt - CNT_W'(MAX_COLS));
    assign w_cur_q    = r_bank ? w_q1 : w_q0;
    assign w_prv_q    = r_bank ? w_q0 : w_q1;
    assign w_we0      = i_cmd.clr || (w_wr && r_bank);
    assign w_we1      = i_cmd.clr || (w_wr && !r_bank);

    wegs_ram #(.DEPTH(CELLS), .WIDTH(VAL_W)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (w_we0),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_bank ? w_prv_addr : w_cur_addr),
        .o_rdata (w_q0)
    );

    wegs_ram #(.DEPTH(CELLS), .WIDTH(VAL_W)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (w_we1),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_bank ? w_cur_addr : w_prv_addr),
        .o_rdata (w_q1)
    );

    // stencil window: r_sh[i] holds the cell read i+1 reads ago
    logic signed [VAL_W-1:0] r_sh [2*MAX_COLS];
    logic                    r_iss1, r_kv1;
    logic [ADDR_W-1:0]       r_k1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss1 <= 1'b0;
            r_kv1  <= 1'b0;
        end else begin
            r_iss1 <= i_cmd.issue;
            r_kv1  <= i_cmd.kvalid;
        end
        r_k1 <= w_prv_addr;
        if (r_iss1) begin
            r_sh[0] <= w_cur_q;
            for (int i = 1; i < 2*MAX_COLS; i++) begin
                r_sh[i] <= r_sh[i-1];
            end
        end
    end

    // stage A: second differences
    logic signed [DIFF_W-1:0] w_twoc, w_dx, w_dy, w_v0;
    assign w_twoc = DIFF_W'(r_sh[MAX_COLS-1]) <<< 1;
    assign w_dx   = DIFF_W'(r_sh[MAX_COLS]) + DIFF_W'(r_sh[MAX_COLS-2]) - w_twoc;
    assign w_dy   = DIFF_W'(r_sh[2*MAX_COLS-1]) + DIFF_W'(w_cur_q) - w_twoc;
    assign w_v0   = w_twoc - DIFF_W'(w_prv_q);

    logic                     r_vA, r_inA, r_dxnA, r_dynA;
    logic [ADDR_W-1:0]        r_kA;
    logic [MAG_W-1:0]         r_dxmA, r_dymA;
    logic signed [DIFF_W-1:0] r_v0A;
    logic [DIFF_W-1:0]        w_dxa, w_dya;

    assign w_dxa = w_dx[DIFF_W-1] ? DIFF_W'(-w_dx) : DIFF_W'(w_dx);
    assign w_dya = w_dy[DIFF_W-1] ? DIFF_W'(-w_dy) : DIFF_W'(w_dy);

    // stage B: coefficient products
    logic                     r_vB, r_inB, r_dxnB, r_dynB;
    logic [ADDR_W-1:0]        r_kB;
    logic [PROD_W-1:0]        r_pxB, r_pyB;
    logic signed [DIFF_W-1:0] r_v0B;

    // stage C: round, sum, saturate
    logic [MAG_W-1:0]         w_rx, w_ry;
    logic [PROD_W-1:0]        w_rxf, w_ryf;
    logic signed [SUM_W-1:0]  w_tx, w_ty, w_sum;
    logic signed [VAL_W-1:0]  w_vc;

    assign w_rxf = r_pxB + PROD_W'(1 << (FRAC_W - 1));
    assign w_ryf = r_pyB + PROD_W'(1 << (FRAC_W - 1));
    assign w_rx  = w_rxf[PROD_W-1:FRAC_W];
    assign w_ry  = w_ryf[PROD_W-1:FRAC_W];
    assign w_tx  = r_dxnB ? -SUM_W'(w_rx) : SUM_W'(w_rx);
    assign w_ty  = r_dynB ? -SUM_W'(w_ry) : SUM_W'(w_ry);
    assign w_sum = SUM_W'(r_v0B) + w_tx + w_ty;
    assign w_vc  = sat_val(w_sum);

    logic                    r_vC, r_inC, r_hitC;
    logic [ADDR_W-1:0]       r_kC;
    logic signed [VAL_W-1:0] r_valC;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vA <= 1'b0;
            r_vB <= 1'b0;
            r_vC <= 1'b0;
        end else begin
            r_vA <= r_kv1;
            r_vB <= r_vA;
            r_vC <= r_vB;
        end
        r_kA   <= r_k1;
        r_inA  <= interior(r_k1[ADDR_W-1:COL_W], r_k1[COL_W-1:0], w_nr, w_nc);
        r_dxnA <= w_dx[DIFF_W-1];
        r_dynA <= w_dy[DIFF_W-1];
        r_dxmA <= w_dxa[MAG_W-1:0];
        r_dymA <= w_dya[MAG_W-1:0];
        r_v0A  <= w_v0;

        r_kB   <= r_kA;
        r_inB  <= r_inA;
        r_dxnB <= r_dxnA;
        r_dynB <= r_dynA;
        r_pxB  <= PROD_W'(r_dxmA) * PROD_W'(r_coef_h);
        r_pyB  <= PROD_W'(r_dymA) * PROD_W'(r_coef_v);
        r_v0B  <= r_v0A;

        r_kC   <= r_kB;
        r_inC  <= r_inB;
        r_valC <= w_vc;
        r_hitC <= (w_vc > LIMIT) || (w_vc < -LIMIT);
    end

    // write-back: source injection and border zeroing
    logic                    w_src_ok, w_src_hit;
    logic signed [VAL_W-1:0] w_srcv;

    assign w_src_ok  = interior(r_src_r, r_src_c, w_nr, w_nc);
    assign w_src_hit = w_src_ok && (r_kC == {r_src_r, r_src_c});
    assign w_srcv    = sat_val(SUM_W'(r_valC) + SUM_W'(r_amp));
    assign w_wr      = r_vC;
    assign w_waddr   = i_cmd.clr ? i_cmd.cnt[ADDR_W-1:0] : r_kC;
    assign w_wdata   = (i_cmd.clr || !r_inC) ? '0 : (w_src_hit ? w_srcv : r_valC);

    // flag, counters and result register
    logic                    r_flag;
    logic [STEPS_W-1:0]      r_steps;
    logic signed [VAL_W-1:0] r_cell;
    logic                    r_exc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank  <= 1'b0;
            r_flag  <= 1'b0;
            r_steps <= '0;
            r_cell  <= '0;
            r_exc   <= 1'b0;
        end else begin
            if (i_cmd.step_start) begin
                r_flag <= 1'b0;
            end else if (r_vC && r_inC && r_hitC) begin
                r_flag <= 1'b1;
            end
            if (i_cmd.step_done) begin
                r_bank  <= !r_bank;
                r_steps <= r_steps + STEPS_W'(1);
                r_cell  <= '0;
                r_exc   <= r_flag;
            end else if (i_cmd.rd_cap) begin
                r_cell  <= w_cur_q;
                r_exc   <= 1'b0;
            end
        end
    end

    assign o_m_tdata = {r_steps, r_cell};
    assign o_m_tuser = r_exc;

endmodule

// ===== design/wave_equation_grid_step.sv =====
// A read runs through the states ST_READ, ST_RWAIT and ST_OUT; the length
// of a step does not depend on the grid size that is set,
// since the sweep always walks the full storage, one cell per cycle.
// One transaction is in flight at a time; the next is taken after the result.
// After reset both grids are cleared; no input is taken then,
// configuration writes are taken at all times.
// ----------------------------------------------------------------------------
// wave_equation_grid_step: 2-D wave equation finite-difference step
// Holds previous and current grids, sweeps the stencil on a step command and
// returns one cell on a read command.
// ----------------------------------------------------------------------------
module wave_equation_grid_step (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] source_amplitude, [37:32] read_row, [43:38] read_col, [47:44] zero
    input  logic [wegs_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] cmd
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] cell_value, [47:32] steps_done
    output logic [wegs_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // [0] exceeded
    output logic                                m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wegs_pkg::IDX_W-1:0]          i_cfg_index,
    input  logic [wegs_pkg::CFG_W-1:0]          i_cfg_data
);
    import wegs_pkg::*;

    t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    wegs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tuser  (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (w_cmd)
    );

    wegs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_s_tdata   (s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser)
    );

endmodule
